@@ design/sgrm_pkg.sv @@
package sgrm_pkg;

  localparam int REGION_SLOTS = 16;
  localparam int TABLE_WIDTH  = 64;
  localparam int HANDLE_BITS  = 16;
  localparam int COORD_BITS   = 16;
  localparam int OP_BITS      = 2;
  localparam int STATUS_BITS  = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam int LOCAL_BITS = $clog2(TABLE_WIDTH);
  localparam int SLOT_BITS  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int BASE_BITS  = COORD_BITS - LOCAL_BITS;
  localparam int ADDR_BITS  = SLOT_BITS + 2 * LOCAL_BITS;
  localparam int QPTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_REGION = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   addr;
    logic [HANDLE_BITS-1:0] wdata;
    logic [STATUS_BITS-1:0] status;
  } cmd_t;

endpackage

@@ design/sgrm_front.sv @@
module sgrm_front import sgrm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic        [OP_BITS-1:0]     in_op,
  input  logic signed [COORD_BITS-1:0]  in_cell_x,
  input  logic signed [COORD_BITS-1:0]  in_cell_z,
  input  logic        [HANDLE_BITS-1:0] in_handle,
  input  logic                          clear_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output cmd_t                          q_cmd
);

  logic [REGION_SLOTS-1:0] valid_r;
  logic [REGION_SLOTS-1:0] valid_nxt;
  logic [BASE_BITS-1:0]    col_r [REGION_SLOTS];
  logic [BASE_BITS-1:0]    row_r [REGION_SLOTS];

  logic [BASE_BITS-1:0]    base_col;
  logic [BASE_BITS-1:0]    base_row;
  logic [LOCAL_BITS-1:0]   local_x;
  logic [LOCAL_BITS-1:0]   local_z;
  logic [REGION_SLOTS-1:0] match;
  logic [SLOT_BITS-1:0]    hit_slot;
  logic [SLOT_BITS-1:0]    free_slot;
  logic                    hit;
  logic                    has_free;
  logic                    alloc;
  logic                    accept;

  assign base_col = in_cell_x[COORD_BITS-1:LOCAL_BITS];
  assign base_row = in_cell_z[COORD_BITS-1:LOCAL_BITS];
  assign local_x  = in_cell_x[LOCAL_BITS-1:0];
  assign local_z  = in_cell_z[LOCAL_BITS-1:0];

  assign in_stall = clear_busy || q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept;

  always_comb begin
    for (int i = 0; i < REGION_SLOTS; i++) begin
      match[i] = valid_r[i] && (col_r[i] == base_col) && (row_r[i] == base_row);
    end
  end

  // The lowest matching slot and the lowest free slot win.
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = SLOT_BITS'(i);
      end
      if (!valid_r[i]) begin
        free_slot = SLOT_BITS'(i);
      end
    end
  end

  assign hit      = |match;
  assign has_free = ~&valid_r;

  always_comb begin
    q_cmd        = '0;
    q_cmd.status = ST_OK;
    q_cmd.addr   = {hit_slot, local_x, local_z};
    alloc        = 1'b0;
    unique case (in_op)
      OP_ADD: begin
        if (hit) begin
          q_cmd.wr_en = 1'b1;
          q_cmd.wdata = in_handle;
        end else if (has_free) begin
          alloc       = 1'b1;
          q_cmd.wr_en = 1'b1;
          q_cmd.wdata = in_handle;
          q_cmd.addr  = {free_slot, local_x, local_z};
        end else begin
          q_cmd.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          q_cmd.wr_en = 1'b1;
        end else begin
          q_cmd.status = ST_NO_REGION;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          q_cmd.rd_en = 1'b1;
        end else begin
          q_cmd.status = ST_NO_REGION;
        end
      end
      default: begin
        q_cmd.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept && alloc) begin
      valid_nxt[free_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && alloc) begin
      col_r[free_slot] <= base_col;
      row_r[free_slot] <= base_row;
    end
  end

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("Two directory slots hold the same region.");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !q_push)
    else $error("A request was taken while the cell memory was being cleared.");

  a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && alloc) |=> ($countones(valid_r) == $countones($past(valid_r)) + 1))
    else $error("An allocation did not claim a new slot.");

endmodule

@@ design/sgrm_queue.sv @@
module sgrm_queue import sgrm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t                 slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_r;
  logic [QPTR_BITS-1:0] wptr_nxt;
  logic [QPTR_BITS-1:0] rptr_r;
  logic [QPTR_BITS-1:0] rptr_nxt;
  logic [QCNT_BITS-1:0] count_r;
  logic [QCNT_BITS-1:0] count_nxt;

  assign full    = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("A command was written into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("A command was taken from an empty queue.");

endmodule

@@ design/sgrm_back.sv @@
module sgrm_back import sgrm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  cmd_t                   q_cmd,
  output logic                   q_pop,
  output logic                   clear_busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [HANDLE_BITS-1:0] out_read_handle,
  output logic [STATUS_BITS-1:0] out_status
);

  logic [HANDLE_BITS-1:0] mem [2**ADDR_BITS];

  logic                   clr_busy_r;
  logic                   clr_busy_nxt;
  logic [ADDR_BITS-1:0]   clr_addr_r;
  logic [ADDR_BITS-1:0]   clr_addr_nxt;

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_rd_r;
  logic [STATUS_BITS-1:0] s1_status_r;
  logic [HANDLE_BITS-1:0] rdata_r;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [HANDLE_BITS-1:0] out_handle_r;
  logic [STATUS_BITS-1:0] out_status_r;

  logic                   out_take;
  logic                   s1_move;

  assign clear_busy      = clr_busy_r;
  assign out_valid       = out_valid_r;
  assign out_read_handle = out_handle_r;
  assign out_status      = out_status_r;

  assign out_take = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_take;
  assign q_pop    = !q_empty && !clr_busy_r && (!s1_valid_r || s1_move);

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == {ADDR_BITS{1'b1}}) begin
        clr_busy_nxt = 1'b0;
      end
    end
    s1_valid_nxt = q_pop || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (q_pop && q_cmd.wr_en) begin
      mem[q_cmd.addr] <= q_cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.rd_en) begin
      rdata_r <= mem[q_cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rd_r     <= q_cmd.rd_en;
      s1_status_r <= q_cmd.status;
    end
    if (s1_move) begin
      out_handle_r <= s1_rd_r ? rdata_r : '0;
      out_status_r <= s1_status_r;
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !out_valid_r))
    else $error("A result appeared while the cell memory was being cleared.");

endmodule

@@ design/sparse_grid_region_map_top.sv @@
// A two-level map from signed grid cells to 16-bit handles: a 16-slot directory of
// 64 by 64 cell regions, found by a parallel compare, in front of a 65536-entry
// handle memory. After reset the block clears that memory, one entry per cycle,
// and holds in_stall high until done. From then on it takes one request per cycle
// unless the queue is full; each gives one result, in order, through the queue,
// the read stage and the output register. The rate is set by the single port of
// the handle memory, which does one read or one write per request. A two-entry
// queue lets the directory keep taking requests while the output is stalled. Regions
// are never freed, so a seventeenth distinct region on add reports directory full.
module sparse_grid_region_map_top import sgrm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic        [OP_BITS-1:0]     in_op,
  input  logic signed [COORD_BITS-1:0]  in_cell_x,
  input  logic signed [COORD_BITS-1:0]  in_cell_z,
  input  logic        [HANDLE_BITS-1:0] in_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic        [HANDLE_BITS-1:0] out_read_handle,
  output logic        [STATUS_BITS-1:0] out_status
);

  logic clear_busy;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  sgrm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_cell_x  (in_cell_x),
    .in_cell_z  (in_cell_z),
    .in_handle  (in_handle),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  sgrm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  sgrm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .clear_busy      (clear_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_handle (out_read_handle),
    .out_status      (out_status)
  );

endmodule
